// File: rtl/xrfe_pkg.sv
// Shared types and constants for the bus receiver with feedback decode.
// Used by xrfe_ctrl, xrfe_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package xrfe_pkg;

   localparam logic [1:0] KIND_POLL = 2'd0;
   localparam logic [1:0] KIND_ERR  = 2'd1;
   localparam logic [1:0] KIND_FB   = 2'd2;
   localparam logic [1:0] KIND_FWD  = 2'd3;

   localparam logic [6:0] CALL_BCAST_MSG = 7'h60;
   localparam logic [6:0] CALL_BCAST_ALT = 7'h20;
   localparam logic [1:0] CALL_POLL_HI   = 2'b10;
   localparam logic [1:0] CALL_MSG_HI    = 2'b11;
   localparam logic [1:0] CALL_ALT_HI    = 2'b01;
   localparam logic [1:0] CALL_ERR_HI    = 2'b00;
   localparam logic [3:0] HDR_FEEDBACK   = 4'h4;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_SINGLE,
      CLS_FINISH
   } cls_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] fb_address;
      logic [2:0] fb_bit;
      logic       fb_level;
      logic [7:0] msg_byte;
   } item_type;

   typedef struct packed {
      logic accept;
      logic init_walk;
      logic latch_a;
      logic latch_b;
      logic next_pair;
      logic mem_rd;
      logic mem_upd;
      logic gen_code;
      logic gen_bit;
      logic gen_fwd;
      logic flush;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    hdr_fb;
      logic    can_gen;
      logic    pend_v;
      logic    out_free;
      logic    pair_ok;
      logic    addr_ok;
      logic    mask_nz;
      logic    fwd_more;
   } stat_type;

endpackage
`default_nettype wire

// File: rtl/xrfe_datapath.sv
// Datapath: message buffer, feedback store, pending and output registers.
// Depends on xrfe_pkg; driven by commands from xrfe_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module xrfe_datapath #(
   parameter int FEEDBACK_ENTRIES = 128,
   parameter int RX_BYTES         = 18,
   parameter int FORWARD_MAX      = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        char_data,
   input  wire logic              call_bit,
   input  wire logic [4:0]        device_id,
   input  wire xrfe_pkg::cmd_type cmd,
   output xrfe_pkg::stat_type     stat,
   input  wire logic              rsp_tready,
   output logic                   rsp_valid,
   output xrfe_pkg::item_type     rsp_item,
   output logic                   rsp_last
);
   localparam int BW = $clog2(RX_BYTES);
   localparam int AW = $clog2(FEEDBACK_ENTRIES);
   localparam logic [5:0] RX_LIM = 6'(RX_BYTES);
   localparam logic [7:0] FB_LIM = 8'(FEEDBACK_ENTRIES);
   localparam logic [4:0] FWD_LIM = 5'(FORWARD_MAX);

   logic [7:0] buf_ff [RX_BYTES];
   logic [7:0] mem_ff [FEEDBACK_ENTRIES];
   logic [FEEDBACK_ENTRIES-1:0] vld_ff;

   logic [4:0] cnt_ff, len_ff, pi_ff, k_ff;
   logic       inmsg_ff;
   logic [7:0] hdr_ff, a_ff, b_ff, rd_ff, nw_ff, diff_ff;
   logic       rdv_ff;
   logic [1:0] kind_ff;
   logic       pend_v_ff, out_v_ff, last_ff;
   xrfe_pkg::item_type pend_ff, out_ff;

   logic [6:0] c;
   logic is_poll, is_start, is_err;
   logic [4:0] ncnt, fwd_cnt, rd_sel;
   logic [7:0] buf_rd, old, nw;
   logic [2:0] lsb;
   xrfe_pkg::item_type new_item;

   always_comb begin
      c = char_data[6:0];
      is_poll  = c == {xrfe_pkg::CALL_POLL_HI, device_id};
      is_start = c == xrfe_pkg::CALL_BCAST_MSG || c == {xrfe_pkg::CALL_MSG_HI, device_id}
              || c == xrfe_pkg::CALL_BCAST_ALT || c == {xrfe_pkg::CALL_ALT_HI, device_id};
      is_err   = c == {xrfe_pkg::CALL_ERR_HI, device_id};
      ncnt = cnt_ff + 5'd1;
      stat.cls = xrfe_pkg::CLS_NONE;
      if (call_bit) begin
         if (is_poll || (!is_start && is_err)) stat.cls = xrfe_pkg::CLS_SINGLE;
      end else if (inmsg_ff && ncnt != 5'd2
                   && (ncnt > len_ff || {1'b0, ncnt} >= RX_LIM)) begin
         stat.cls = xrfe_pkg::CLS_FINISH;
      end
      fwd_cnt = ({1'b0, hdr_ff[3:0]} + 5'd2 > FWD_LIM) ? FWD_LIM
              : {1'b0, hdr_ff[3:0]} + 5'd2;
      if (cmd.gen_fwd) rd_sel = k_ff + 5'd1;
      else if (cmd.latch_b) rd_sel = pi_ff + 5'd1;
      else rd_sel = pi_ff;
      buf_rd = buf_ff[rd_sel[BW-1:0]];
      old = rdv_ff ? rd_ff : 8'd0;
      nw = b_ff[4] ? {b_ff[3:0], old[3:0]} : {old[7:4], b_ff[3:0]};
      lsb = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (diff_ff[j]) lsb = 3'(j);
      end
      new_item = '0;
      if (cmd.gen_code) begin
         new_item.kind = kind_ff;
      end else if (cmd.gen_bit) begin
         new_item.kind = xrfe_pkg::KIND_FB;
         new_item.fb_address = a_ff[6:0];
         new_item.fb_bit = lsb;
         new_item.fb_level = nw_ff[lsb];
      end else begin
         new_item.kind = xrfe_pkg::KIND_FWD;
         new_item.msg_byte = buf_rd;
      end
      stat.hdr_fb   = hdr_ff[7:4] == xrfe_pkg::HDR_FEEDBACK;
      stat.can_gen  = !pend_v_ff || !out_v_ff;
      stat.pend_v   = pend_v_ff;
      stat.out_free = !out_v_ff;
      stat.pair_ok  = pi_ff <= {1'b0, hdr_ff[3:0]};
      stat.addr_ok  = {1'b0, a_ff[6:0]} < FB_LIM;
      stat.mask_nz  = diff_ff != 8'd0;
      stat.fwd_more = k_ff < fwd_cnt;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !call_bit && inmsg_ff && {1'b0, cnt_ff} < RX_LIM)
         buf_ff[cnt_ff[BW-1:0]] <= char_data;
      if (cmd.accept && !call_bit && inmsg_ff && cnt_ff == 5'd1) hdr_ff <= char_data;
      if (cmd.accept) kind_ff <= is_poll ? xrfe_pkg::KIND_POLL : xrfe_pkg::KIND_ERR;
      if (cmd.latch_a) a_ff <= buf_rd;
      if (cmd.latch_b) b_ff <= buf_rd;
      if (cmd.mem_rd) begin
         rd_ff <= mem_ff[a_ff[AW-1:0]];
         rdv_ff <= vld_ff[a_ff[AW-1:0]];
      end
      if (cmd.mem_upd) begin
         mem_ff[a_ff[AW-1:0]] <= nw;
         nw_ff <= nw;
      end
      if (cmd.gen_code || cmd.gen_bit || cmd.gen_fwd) begin
         pend_ff <= new_item;
         if (pend_v_ff) out_ff <= pend_ff;
      end else if (cmd.flush) begin
         out_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= '0;
         len_ff <= '0;
         inmsg_ff <= 1'b0;
         pi_ff <= '0;
         k_ff <= '0;
         diff_ff <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (call_bit) begin
               if (!is_poll && is_start) begin
                  buf_ff_start: begin
                     cnt_ff <= 5'd1;
                     inmsg_ff <= 1'b1;
                  end
               end else if (!is_poll && is_err) begin
                  inmsg_ff <= 1'b0;
               end
            end else if (inmsg_ff) begin
               cnt_ff <= ncnt;
               if (ncnt == 5'd2) len_ff <= {1'b0, char_data[3:0]} + 5'd2;
               else if (stat.cls == xrfe_pkg::CLS_FINISH) inmsg_ff <= 1'b0;
            end
         end
         if (cmd.init_walk) begin
            pi_ff <= 5'd2;
            k_ff <= 5'd0;
         end
         if (cmd.next_pair) pi_ff <= pi_ff + 5'd2;
         if (cmd.gen_fwd) k_ff <= k_ff + 5'd1;
         if (cmd.mem_upd) begin
            vld_ff[a_ff[AW-1:0]] <= 1'b1;
            diff_ff <= nw ^ old;
         end
         if (cmd.gen_bit) diff_ff[lsb] <= 1'b0;
         if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         if (cmd.gen_code || cmd.gen_bit || cmd.gen_fwd) begin
            pend_v_ff <= 1'b1;
            if (pend_v_ff) begin
               out_v_ff <= 1'b1;
               last_ff <= 1'b0;
            end
         end else if (cmd.flush) begin
            pend_v_ff <= 1'b0;
            out_v_ff <= 1'b1;
            last_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_ff;
   assign rsp_last  = last_ff;
endmodule
`default_nettype wire

// File: rtl/xrfe_ctrl.sv
// Controller: sequences single replies, message finish, forwarding, pair walk, bit scan and output flush.
// Depends on xrfe_pkg; issues commands to xrfe_datapath.
`timescale 1ns / 1ps
`default_nettype none
module xrfe_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire xrfe_pkg::stat_type stat,
   output xrfe_pkg::cmd_type       cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_SINGLE, S_FWD, S_PAIR, S_PAIRB, S_UPD, S_BITS, S_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               case (stat.cls)
                  xrfe_pkg::CLS_SINGLE: state_in = S_SINGLE;
                  xrfe_pkg::CLS_FINISH: begin
                     cmd.init_walk = 1'b1;
                     state_in = stat.hdr_fb ? S_PAIR : S_FWD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SINGLE: begin
            if (stat.can_gen) begin
               cmd.gen_code = 1'b1;
               state_in = S_FLUSH;
            end
         end
         S_FWD: begin
            if (!stat.fwd_more) state_in = S_FLUSH;
            else if (stat.can_gen) cmd.gen_fwd = 1'b1;
         end
         S_PAIR: begin
            if (!stat.pair_ok) state_in = S_FLUSH;
            else begin
               cmd.latch_a = 1'b1;
               state_in = S_PAIRB;
            end
         end
         S_PAIRB: begin
            cmd.latch_b = 1'b1;
            cmd.next_pair = 1'b1;
            if (stat.addr_ok) begin
               cmd.mem_rd = 1'b1;
               state_in = S_UPD;
            end else state_in = S_PAIR;
         end
         S_UPD: begin
            cmd.mem_upd = 1'b1;
            state_in = S_BITS;
         end
         S_BITS: begin
            if (!stat.mask_nz) state_in = S_PAIR;
            else if (stat.can_gen) cmd.gen_bit = 1'b1;
         end
         S_FLUSH: begin
            if (!stat.pend_v) state_in = S_IDLE;
            else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// File: rtl/xbus_receiver_feedback_events_core.sv
// Top level of the bus receiver with feedback decode.
// Depends on xrfe_pkg, xrfe_ctrl and xrfe_datapath.
`timescale 1ns / 1ps
`default_nettype none
// One request is a 9-bit bus character. Calls, data bytes that do not end a
// message and ignored characters are handled in the idle state; poll and
// error replies pass through a reply state. A finished feedback message walks
// its pairs through the controller: it fetches address and data of each pair,
// reads and merges the feedback store entry, then emits one event per changed
// bit. A forwarded message emits its bytes. No character is taken until this
// is done. Results leave through an output register; the last one carries
// tlast. The feedback store clears at reset through per-entry valid bits.
module xbus_receiver_feedback_events_core #(
   parameter int FEEDBACK_ENTRIES = 128,
   parameter int RX_BYTES         = 18,
   parameter int FORWARD_MAX      = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data,     // device_id
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // char_data
   input  wire logic        req_tuser,    // call_bit
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,    // fb_address, fb_bit, fb_level, msg_byte, zeros
   output logic [1:0]       rsp_tuser,    // kind
   output logic             rsp_tlast     // last
);
   logic [4:0] device_id_ff;
   xrfe_pkg::cmd_type  cmd;
   xrfe_pkg::stat_type stat;
   xrfe_pkg::item_type item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) device_id_ff <= 5'd29;
      else if (csr_valid) device_id_ff <= csr_data;
   end

   xrfe_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .stat(stat), .cmd(cmd)
   );

   xrfe_datapath #(
      .FEEDBACK_ENTRIES(FEEDBACK_ENTRIES), .RX_BYTES(RX_BYTES), .FORWARD_MAX(FORWARD_MAX)
   ) u_dp (
      .clock(clock), .reset(reset), .char_data(req_tdata), .call_bit(req_tuser),
      .device_id(device_id_ff), .cmd(cmd), .stat(stat), .rsp_tready(rsp_tready),
      .rsp_valid(rsp_tvalid), .rsp_item(item), .rsp_last(rsp_tlast)
   );

   assign rsp_tuser = item.kind;
   assign rsp_tdata = {5'd0, item.msg_byte, item.fb_level, item.fb_bit, item.fb_address};
endmodule
`default_nettype wire
